@@ rtl/maximal_palindrome_finder_top_defines.svh @@
// Assertion macros shared by the palindrome finder RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using scope.
`ifndef MAXIMAL_PALINDROME_FINDER_TOP_DEFINES_SVH
`define MAXIMAL_PALINDROME_FINDER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MPF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mpf_pkg.sv @@
// Types and constants of the maximal palindrome finder.
// No dependencies; used by maximal_palindrome_finder_top.
package mpf_pkg;

    localparam int SYMBOL_W = 8;
    localparam int SPAN_W   = 5;

    typedef struct packed {
        logic [SYMBOL_W-1:0] symbol;
        logic                is_last;
    } item_t;

    typedef struct packed {
        logic [SPAN_W-1:0] span_start;
        logic [SPAN_W-1:0] span_end;
        logic              found;
        logic              truncated;
        logic              last_result;
    } result_t;

endpackage

@@ rtl/maximal_palindrome_finder_top.sv @@
// No item is taken while a search runs. After the last symbol the search visits 2n centers;
// for each symbol pair compared it passes S_PROBE and S_CMP, S_FINISH closes the center, and a
// probe past the string edge goes straight from S_PROBE to S_FINISH. A closing transaction
// with last_result ends the run, and a stalled output holds the search.
// Reset clears the count, flags and control, not the symbol memory (only current-run entries
// are read). Depends on mpf_pkg and maximal_palindrome_finder_top_defines.svh.
`include "maximal_palindrome_finder_top_defines.svh"

module maximal_palindrome_finder_top #(
    parameter int MAX_LEN = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            item_valid,
    output logic            item_stall,
    input  mpf_pkg::item_t  item,
    output logic            result_valid,
    input  logic            result_stall,
    output mpf_pkg::result_t result
);

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int PW = $clog2(MAX_LEN + 2);

    typedef enum logic [2:0] {
        S_LOAD,
        S_PROBE,
        S_CMP,
        S_FINISH,
        S_DONE
    } state_t;

    state_t                          state_reg;
    logic [CW-1:0]                   count_reg;
    logic                            overflow_reg;
    logic [CW-1:0]                   n_reg;
    logic [AW-1:0]                   i_reg;
    logic                            gap2_reg;
    logic [PW-1:0]                   lo1_reg;
    logic [PW-1:0]                   hi_reg;
    logic                            pend_valid_reg;
    logic [mpf_pkg::SPAN_W-1:0]      pend_start_reg;
    logic [mpf_pkg::SPAN_W-1:0]      pend_end_reg;
    logic                            result_valid_reg;
    mpf_pkg::result_t                result_reg;

    logic [mpf_pkg::SYMBOL_W-1:0]    mem [MAX_LEN];
    logic [mpf_pkg::SYMBOL_W-1:0]    rd_lo_reg;
    logic [mpf_pkg::SYMBOL_W-1:0]    rd_hi_reg;

    logic                            accept;
    logic                            wr_en;
    logic [CW-1:0]                   count_next;
    logic [AW-1:0]                   rd_lo_addr;
    logic                            in_bounds;
    logic                            have_span;
    logic                            last_center;
    logic                            out_free;
    logic                            result_load;

    assign item_stall   = (state_reg != S_LOAD);
    assign accept       = item_valid && !item_stall;
    assign wr_en        = accept && (count_reg < CW'(MAX_LEN));
    assign count_next   = count_reg + CW'(wr_en);
    assign rd_lo_addr   = AW'(lo1_reg - PW'(1));
    // lo1_reg holds the left index plus one, so zero means the left edge was passed.
    assign in_bounds    = (lo1_reg != '0) && (hi_reg < PW'(n_reg));
    // The span runs from lo1_reg to hi_reg - 1; hi_reg never falls below lo1_reg.
    assign have_span    = (hi_reg - lo1_reg) >= PW'(2);
    assign last_center  = (PW'(i_reg) + PW'(1)) == PW'(n_reg);
    assign out_free     = !result_valid_reg || !result_stall;
    // A new transaction is loaded into the output register in this cycle.
    assign result_load  = out_free &&
                          (((state_reg == S_FINISH) && have_span && pend_valid_reg) ||
                           (state_reg == S_DONE));
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Symbol memory: one write port for loading, two registered read ports for the search.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= item.symbol;
        end
        rd_lo_reg <= mem[rd_lo_addr];
        rd_hi_reg <= mem[hi_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_LOAD;
            count_reg        <= '0;
            overflow_reg     <= 1'b0;
            n_reg            <= '0;
            i_reg            <= '0;
            gap2_reg         <= 1'b0;
            lo1_reg          <= '0;
            hi_reg           <= '0;
            pend_valid_reg   <= 1'b0;
            pend_start_reg   <= '0;
            pend_end_reg     <= '0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (result_valid_reg && !result_stall && !result_load)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        count_reg <= count_next;
                        if (!wr_en)
                        begin
                            overflow_reg <= 1'b1;
                        end
                        if (item.is_last)
                        begin
                            n_reg     <= count_next;
                            i_reg     <= '0;
                            gap2_reg  <= 1'b1;
                            lo1_reg   <= PW'(1);
                            hi_reg    <= PW'(2);
                            state_reg <= S_PROBE;
                        end
                    end
                end

                S_PROBE:
                begin
                    state_reg <= in_bounds ? S_CMP : S_FINISH;
                end

                S_CMP:
                begin
                    if (rd_lo_reg == rd_hi_reg)
                    begin
                        lo1_reg   <= lo1_reg - PW'(1);
                        hi_reg    <= hi_reg + PW'(1);
                        state_reg <= S_PROBE;
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end

                S_FINISH:
                begin
                    // The newest span is held back until it is known whether it ends the run.
                    if (!(have_span && pend_valid_reg && !out_free))
                    begin
                        if (have_span)
                        begin
                            if (pend_valid_reg)
                            begin
                                result_reg.span_start  <= pend_start_reg;
                                result_reg.span_end    <= pend_end_reg;
                                result_reg.found       <= 1'b1;
                                result_reg.truncated   <= overflow_reg;
                                result_reg.last_result <= 1'b0;
                                result_valid_reg       <= 1'b1;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_start_reg <= mpf_pkg::SPAN_W'(lo1_reg);
                            pend_end_reg   <= mpf_pkg::SPAN_W'(hi_reg - PW'(1));
                        end

                        if (last_center)
                        begin
                            if (gap2_reg)
                            begin
                                gap2_reg  <= 1'b0;
                                i_reg     <= '0;
                                lo1_reg   <= PW'(1);
                                hi_reg    <= PW'(1);
                                state_reg <= S_PROBE;
                            end
                            else
                            begin
                                state_reg <= S_DONE;
                            end
                        end
                        else
                        begin
                            i_reg     <= i_reg + AW'(1);
                            lo1_reg   <= PW'(i_reg) + PW'(2);
                            hi_reg    <= PW'(i_reg) + (gap2_reg ? PW'(3) : PW'(2));
                            state_reg <= S_PROBE;
                        end
                    end
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        result_reg.span_start  <= pend_valid_reg ? pend_start_reg : '0;
                        result_reg.span_end    <= pend_valid_reg ? pend_end_reg : '0;
                        result_reg.found       <= pend_valid_reg;
                        result_reg.truncated   <= overflow_reg;
                        result_reg.last_result <= 1'b1;
                        result_valid_reg       <= 1'b1;
                        pend_valid_reg         <= 1'b0;
                        count_reg              <= '0;
                        overflow_reg           <= 1'b0;
                        state_reg              <= S_LOAD;
                    end
                end

                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    `MPF_ASSERT_SAME(a_empty_marker_ends_run, result_valid && !result.found, result.last_result, "empty marker without last_result")
    `MPF_ASSERT_SAME(a_span_at_least_two, result_valid && result.found, result.span_end > result.span_start, "reported span shorter than two symbols")
    `MPF_ASSERT_NEXT(a_full_store_sets_overflow, accept && (count_reg == CW'(MAX_LEN)), overflow_reg, "dropped symbol did not set overflow")

endmodule
